FILE: src/matrix_keypad_scan_debounce_macros.svh
// assertion macros for the keypad scanner
`ifndef MATRIX_KEYPAD_SCAN_DEBOUNCE_MACROS_SVH
`define MATRIX_KEYPAD_SCAN_DEBOUNCE_MACROS_SVH

// same-cycle implication
`define KPS_ASSERT_NOW(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication
`define KPS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

FILE: src/kps_pkg.sv
`timescale 1ns / 1ps

package kps_pkg;

   localparam int ROWS      = 8;
   localparam int COLUMNS   = 5;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W     = $clog2(COLUMNS + 1);
   localparam int COL_IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int WATCH_MAX = (ROWS < 8) ? ROWS : 8;

   localparam int IN_W      = 8;
   localparam int CNT_W     = 16;
   localparam int RIU_W     = 4;
   localparam int DRIVE_W   = 5;
   localparam int KROW_W    = 3;
   localparam int KCOL_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(15);
   localparam logic [CNT_W-1:0] BEEP_RESET     = CNT_W'(20);
   localparam logic [RIU_W-1:0] ROWS_RESET     = RIU_W'(8);

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS     = CSR_IDX_W'(2);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_DEBOUNCE,
      MODE_SETTLE,
      MODE_SCAN
   } mode_type;

   typedef struct packed {
      logic [CNT_W-1:0] debounce_ticks;
      logic [CNT_W-1:0] beep_ticks;
      logic [RIU_W-1:0] rows_in_use;
   } cfg_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] column_drive;
      logic               key_event;
      logic [KROW_W-1:0]  key_row;
      logic [KCOL_W-1:0]  key_column;
      logic               key_down;
      logic               beeper;
   } result_type;

endpackage

FILE: src/kps_csr.sv
`timescale 1ns / 1ps

module kps_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kps_pkg::CNT_W-1:0]       csr_data,
   output kps_pkg::cfg_type                cfg
);
   import kps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ticks = csr_data;
            CSR_BEEP:     cfg_in.beep_ticks     = csr_data;
            CSR_ROWS:     cfg_in.rows_in_use    = csr_data[RIU_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.beep_ticks     <= BEEP_RESET;
         cfg_ff.rows_in_use    <= ROWS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: src/kps_scan.sv
`timescale 1ns / 1ps

module kps_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [kps_pkg::IN_W-1:0]   rows,
   input  kps_pkg::cfg_type           cfg,
   output kps_pkg::result_type        result
);
   import kps_pkg::*;

   mode_type                mode_ff, mode_in;
   logic [IN_W-1:0]         last_rows_ff, last_rows_in;
   logic [ROW_W-1:0]        active_row_ff, active_row_in;
   logic [COL_W-1:0]        scan_column_ff, scan_column_in;
   logic [CNT_W-1:0]        debounce_count_ff, debounce_count_in;
   logic [CNT_W-1:0]        beep_count_ff, beep_count_in;
   logic [COLUMNS-1:0]      toggles_ff [ROWS];

   logic [IN_W-1:0]         watch_mask;
   logic [IN_W-1:0]         falls;
   logic [ROW_W-1:0]        first_fall;
   logic                    row_low;
   logic                    debounce_done;
   logic                    hit;
   logic [COL_W-1:0]        next_column;
   logic                    key_bit_now;
   logic [COLUMNS-1:0]      drive;
   logic                    event_now;

   // watched rows and falling edges
   always_comb begin
      for (int i = 0; i < IN_W; i++) begin
         watch_mask[i] = (cfg.rows_in_use > RIU_W'(i)) && (i < WATCH_MAX);
      end
      falls = last_rows_ff & ~rows & watch_mask;
      first_fall = '0;
      for (int i = IN_W - 1; i >= 0; i--) begin
         if (falls[i]) begin
            first_fall = ROW_W'(i);
         end
      end
   end

   assign row_low       = ~rows[active_row_ff];
   assign debounce_done = (debounce_count_ff <= CNT_W'(1));
   assign hit           = row_low && (scan_column_ff < COL_W'(COLUMNS));
   assign next_column   = scan_column_ff + COL_W'(1);
   assign key_bit_now   = toggles_ff[active_row_ff][scan_column_ff[COL_IDX_W-1:0]];

   // next state
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_IDLE: begin
            if (falls != '0) mode_in = MODE_DEBOUNCE;
         end
         MODE_DEBOUNCE: begin
            if (debounce_done) mode_in = row_low ? MODE_SETTLE : MODE_IDLE;
         end
         MODE_SETTLE: begin
            mode_in = MODE_SCAN;
         end
         MODE_SCAN: begin
            if (hit || next_column >= COL_W'(COLUMNS)) mode_in = MODE_IDLE;
         end
         default: mode_in = MODE_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      active_row_in     = active_row_ff;
      scan_column_in    = scan_column_ff;
      debounce_count_in = debounce_count_ff;
      drive             = '0;
      event_now         = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (falls != '0) begin
               active_row_in     = first_fall;
               debounce_count_in = cfg.debounce_ticks;
            end
         end
         MODE_DEBOUNCE: begin
            if (debounce_done) begin
               debounce_count_in = '0;
               if (row_low) drive = '1;
            end else begin
               debounce_count_in = debounce_count_ff - CNT_W'(1);
            end
         end
         MODE_SETTLE: begin
            scan_column_in = '0;
            drive          = ~COLUMNS'(1);
         end
         MODE_SCAN: begin
            if (hit) begin
               event_now = 1'b1;
            end else begin
               scan_column_in = next_column;
               if (next_column < COL_W'(COLUMNS)) begin
                  drive = ~(COLUMNS'(1) << next_column);
               end
            end
         end
         default: drive = '0;
      endcase

      if (event_now) begin
         beep_count_in = cfg.beep_ticks;
      end else if (beep_count_ff != '0) begin
         beep_count_in = beep_count_ff - CNT_W'(1);
      end else begin
         beep_count_in = '0;
      end
      last_rows_in = rows;

      for (int i = 0; i < DRIVE_W; i++) begin
         result.column_drive[i] = (i < COLUMNS) ? drive[i % COLUMNS] : 1'b0;
      end
      result.key_event  = event_now;
      result.key_row    = event_now ? KROW_W'(active_row_ff) : '0;
      result.key_column = event_now ? KCOL_W'(scan_column_ff) : '0;
      result.key_down   = event_now & ~key_bit_now;
      result.beeper     = (beep_count_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_IDLE;
         last_rows_ff      <= '1;
         active_row_ff     <= '0;
         scan_column_ff    <= '0;
         debounce_count_ff <= '0;
         beep_count_ff     <= '0;
         for (int r = 0; r < ROWS; r++) begin
            toggles_ff[r] <= '0;
         end
      end else if (step) begin
         mode_ff           <= mode_in;
         last_rows_ff      <= last_rows_in;
         active_row_ff     <= active_row_in;
         scan_column_ff    <= scan_column_in;
         debounce_count_ff <= debounce_count_in;
         beep_count_ff     <= beep_count_in;
         if (event_now) begin
            toggles_ff[active_row_ff][scan_column_ff[COL_IDX_W-1:0]] <= ~key_bit_now;
         end
      end
   end

endmodule

FILE: src/matrix_keypad_scan_debounce.sv
`timescale 1ns / 1ps
// Keypad matrix scanner with debounce and a toggle bit per key. Each req transfer is one
// sampling tick of the active-low row lines and yields exactly one rsp transfer: the column
// levels to drive for the next tick, an optional key report (row, column, new toggle bit)
// and the beeper level. The block takes one tick per clock cycle while rsp_tready is high; a
// tick passes through an input register and the scan state machine into the result register,
// which drives rsp_tvalid, and a low rsp_tready holds the next tick in the input register.
// Configuration is written through the csr port by the user while no tick is in flight;
// the block itself does not enforce this.
`include "matrix_keypad_scan_debounce_macros.svh"

module matrix_keypad_scan_debounce (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] row_levels
   input  logic [kps_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [4:0] column_drive, [7:5] key_row, [10:8] key_column, [11] key_down, [12] beeper
   output logic [kps_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // [0] key_event
   output logic                                 rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [kps_pkg::CNT_W-1:0]            csr_data
);
   import kps_pkg::*;

   cfg_type         cfg;
   result_type      result;
   result_type      rsp_ff;
   logic            in_valid_ff;
   logic [IN_W-1:0] in_rows_ff;
   logic            rsp_valid_ff;
   logic            advance;

   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   kps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kps_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .rows   (in_rows_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid & req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid & req_tready) begin
         in_rows_ff <= req_tdata[IN_W-1:0];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.key_event;
   assign rsp_tdata  = {3'b000, rsp_ff.beeper, rsp_ff.key_down, rsp_ff.key_column,
                        rsp_ff.key_row, rsp_ff.column_drive};

   `KPS_ASSERT_NEXT(a_req_lands, clock, reset, req_tvalid && req_tready, in_valid_ff, "req transfer lost")
   `KPS_ASSERT_NEXT(a_step_lands, clock, reset, advance, rsp_valid_ff, "result not registered")
   `KPS_ASSERT_NOW(a_event_idle_cols, clock, reset, rsp_valid_ff && rsp_ff.key_event, rsp_ff.column_drive == '0, "report with columns driven")
   `KPS_ASSERT_NOW(a_quiet_fields, clock, reset, rsp_valid_ff && !rsp_ff.key_event, rsp_ff.key_row == '0 && rsp_ff.key_column == '0 && !rsp_ff.key_down, "key fields set without report")

endmodule
